FILE: rtl/core/rptc_pkg.sv
// ============================================================================
// rptc_pkg - shared types and helpers for the RGB to palette code unit
// Stage payload structs, mode constants and the divider step function.
// ============================================================================
package rptc_pkg;

    // Configuration
    localparam logic [1:0] MODE_8BIT  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd3;

    // Hue offset: (q - 49 + 128) keeps only 6 bits, so 79 mod 64
    localparam logic [5:0] HUE_OFFSET = 6'd15;

    // Saturation rounding term and clamp
    localparam logic [16:0] SAT_ROUND = 17'd1024;
    localparam logic [3:0]  SAT_MAX   = 4'd15;

    // Input item
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    // After luma
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] red;
        logic [7:0] blue;
    } t_s1;

    // After chroma
    typedef struct packed {
        logic        [7:0]  luma;
        logic signed [16:0] u;
        logic signed [16:0] v;
    } t_s2;

    // After fold and saturation; also carried through the divider
    typedef struct packed {
        logic [7:0] luma;
        logic [3:0] sat;
        logic [7:0] x;     // folded larger component
        logic [7:0] rem;   // running remainder (starts as the smaller one)
        logic [5:0] quo;   // quotient bits so far
        logic       nx;
        logic       ny;
        logic       sw;
        logic       zero;  // zero chroma vector
    } t_div;

    // One restoring division step
    typedef struct packed {
        logic       q;
        logic [8:0] rem;
    } t_dstep;

    function automatic t_dstep rptc_div_step(logic [8:0] rem, logic [7:0] den);
        t_dstep res;
        res.q   = (rem >= {1'b0, den});
        res.rem = res.q ? (rem - {1'b0, den}) : rem;
        return res;
    endfunction

endpackage

FILE: rtl/core/rptc_luma_chroma.sv
// ============================================================================
// rptc_luma_chroma - luma and chroma stages
// Stage 1 forms luma by constant weights, stage 2 the scaled chroma pair.
// ============================================================================
module rptc_luma_chroma (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rptc_pkg::t_pix    i_pix,
    output logic              o_valid,
    input  logic              i_ready,
    output rptc_pkg::t_s2     o_data
);

    logic          r_v1;
    logic          r_v2;
    rptc_pkg::t_s1 r_s1;
    rptc_pkg::t_s1 n_s1;
    rptc_pkg::t_s2 r_s2;
    rptc_pkg::t_s2 n_s2;
    logic          w_rdy1;
    logic          w_rdy2;
    logic [15:0]   w_wsum;
    logic signed [8:0] w_db;
    logic signed [8:0] w_dr;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

    // Luma: weighted sum, top byte
    always_comb begin
        w_wsum = 16'd77 * 16'(i_pix.red) + 16'd29 * 16'(i_pix.blue)
               + 16'd150 * 16'(i_pix.green);
        n_s1.luma = w_wsum[15:8];
        n_s1.red  = i_pix.red;
        n_s1.blue = i_pix.blue;
    end

    // Chroma: scaled differences from luma
    always_comb begin
        w_db = $signed({1'b0, r_s1.blue}) - $signed({1'b0, r_s1.luma});
        w_dr = $signed({1'b0, r_s1.red})  - $signed({1'b0, r_s1.luma});
        n_s2.luma = r_s1.luma;
        n_s2.u    = 17'(w_db) * 17'sd126;
        n_s2.v    = 17'(w_dr) * 17'sd224;
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) r_s1 <= n_s1;
        if (w_rdy2 && r_v1)    r_s2 <= n_s2;
    end

endmodule

FILE: rtl/core/rptc_fold_sat.sv
// ============================================================================
// rptc_fold_sat - octant fold and saturation
// Folds the shifted chroma pair into the first octant and forms the
// clamped saturation from the chroma magnitudes.
// ============================================================================
module rptc_fold_sat (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rptc_pkg::t_s2     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rptc_pkg::t_div    o_data
);

    logic              r_v;
    rptc_pkg::t_div    r_d;
    rptc_pkg::t_div    n_d;
    logic              w_rdy;
    logic signed [8:0] w_y;
    logic signed [8:0] w_x;
    logic [7:0]        w_ay;
    logic [7:0]        w_ax;
    logic [15:0]       w_au;
    logic [15:0]       w_av;
    logic [15:0]       w_max;
    logic [15:0]       w_min;
    logic [17:0]       w_min3;
    logic [16:0]       w_ssum;
    logic [5:0]        w_sat;
    logic [3:0]        w_sat_c;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_data  = r_d;

    // Floor shift by 8, fold to first octant
    always_comb begin
        w_y  = i_data.v[16:8];
        w_x  = i_data.u[16:8];
        w_ay = w_y[8] ? 8'(-w_y) : w_y[7:0];
        w_ax = w_x[8] ? 8'(-w_x) : w_x[7:0];
        n_d.ny   = w_y[8];
        n_d.nx   = w_x[8];
        n_d.sw   = (w_ay > w_ax);
        n_d.x    = n_d.sw ? w_ay : w_ax;
        n_d.rem  = n_d.sw ? w_ax : w_ay;
        n_d.zero = (n_d.x == 8'd0);
        n_d.quo  = 6'd0;
        n_d.luma = i_data.luma;
        n_d.sat  = w_sat_c;
    end

    // Saturation: max + 3*min/8 + 1024, >> 11, clamp
    always_comb begin
        w_au   = i_data.u[16] ? 16'(-i_data.u) : i_data.u[15:0];
        w_av   = i_data.v[16] ? 16'(-i_data.v) : i_data.v[15:0];
        w_max  = (w_au > w_av) ? w_au : w_av;
        w_min  = (w_au > w_av) ? w_av : w_au;
        w_min3 = {1'b0, w_min, 1'b0} + {2'b00, w_min};
        w_ssum = {1'b0, w_max} + {2'b00, w_min3[17:3]} + rptc_pkg::SAT_ROUND;
        w_sat  = w_ssum[16:11];
        w_sat_c = (w_sat > 6'(rptc_pkg::SAT_MAX)) ? rptc_pkg::SAT_MAX : w_sat[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) r_d <= n_d;
    end

endmodule

FILE: rtl/core/rptc_divider.sv
// ============================================================================
// rptc_divider - octant ratio divider
// Restoring division (y*32)/x, six quotient bits over two stages of three.
// ============================================================================
module rptc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rptc_pkg::t_div    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rptc_pkg::t_div    o_data
);

    logic               r_va;
    logic               r_vb;
    rptc_pkg::t_div     r_a;
    rptc_pkg::t_div     n_a;
    rptc_pkg::t_div     r_b;
    rptc_pkg::t_div     n_b;
    logic               w_rdya;
    logic               w_rdyb;
    rptc_pkg::t_dstep   w_a0, w_a1, w_a2;
    rptc_pkg::t_dstep   w_b0, w_b1, w_b2;

    assign w_rdyb  = !r_vb || i_ready;
    assign w_rdya  = !r_va || w_rdyb;
    assign o_ready = w_rdya;
    assign o_valid = r_vb;
    assign o_data  = r_b;

    // Quotient bits 5..3 (first step compares without shift)
    always_comb begin
        w_a0 = rptc_pkg::rptc_div_step({1'b0, i_data.rem}, i_data.x);
        w_a1 = rptc_pkg::rptc_div_step({w_a0.rem[7:0], 1'b0}, i_data.x);
        w_a2 = rptc_pkg::rptc_div_step({w_a1.rem[7:0], 1'b0}, i_data.x);
        n_a      = i_data;
        n_a.rem  = w_a2.rem[7:0];
        n_a.quo  = {w_a0.q, w_a1.q, w_a2.q, 3'b000};
    end

    // Quotient bits 2..0
    always_comb begin
        w_b0 = rptc_pkg::rptc_div_step({r_a.rem, 1'b0}, r_a.x);
        w_b1 = rptc_pkg::rptc_div_step({w_b0.rem[7:0], 1'b0}, r_a.x);
        w_b2 = rptc_pkg::rptc_div_step({w_b1.rem[7:0], 1'b0}, r_a.x);
        n_b      = r_a;
        n_b.rem  = w_b2.rem[7:0];
        n_b.quo  = {r_a.quo[5:3], w_b0.q, w_b1.q, w_b2.q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_rdya) r_va <= i_valid;
            if (w_rdyb) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdya && i_valid) r_a <= n_a;
        if (w_rdyb && r_va)    r_b <= n_b;
    end

endmodule

FILE: rtl/core/rptc_encode.sv
// ============================================================================
// rptc_encode - hue unfold and code packing
// Unfolds the octant angle to hue and packs the palette code; this is the
// output register of the unit.
// ============================================================================
module rptc_encode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_mode,
    input  logic              i_valid,
    output logic              o_ready,
    input  rptc_pkg::t_div    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_code
);

    logic        r_v;
    logic [15:0] r_code;
    logic [15:0] n_code;
    logic        w_rdy;
    logic [6:0]  w_a1;
    logic [7:0]  w_a2;
    logic [8:0]  w_a3;
    logic [5:0]  w_hue;
    logic [3:0]  w_h;
    logic [3:0]  w_sat;
    logic [7:0]  w_luma;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_code  = r_code;

    // Unfold: swap, negative x, negative y; zero vector gives angle 0
    always_comb begin
        w_a1  = i_data.sw ? (7'd64 - 7'(i_data.quo)) : 7'(i_data.quo);
        w_a2  = i_data.nx ? (8'd128 - 8'(w_a1)) : 8'(w_a1);
        w_a3  = i_data.ny ? (9'd0 - 9'(w_a2)) : 9'(w_a2);
        if (i_data.zero) w_a3 = 9'd0;
        // floor(a/4) low bits, plus offset
        w_hue = w_a3[7:2] + rptc_pkg::HUE_OFFSET;
        w_h   = w_hue[5:2];
    end

    // Code packing
    always_comb begin
        w_sat  = i_data.sat;
        w_luma = i_data.luma;
        if (i_mode != rptc_pkg::MODE_8BIT) begin
            if (w_sat == 4'd0) begin
                n_code = {9'd0, w_luma[7:1]};
            end else if (w_sat < 4'd4) begin
                n_code = {w_sat, w_hue[5:1], w_luma[7:1]};
            end else begin
                n_code = {w_sat, w_hue, w_luma[7:2]};
            end
        end else begin
            if (w_sat > 4'd8) begin
                n_code = {8'd0, 2'b11, w_luma[7:6], w_h};
            end else if (w_sat > 4'd4) begin
                n_code = {8'd0, 2'b10, w_luma[7:6], w_h};
            end else if (w_sat > 4'd0) begin
                if (w_luma < 8'd32) n_code = {8'd0, 4'b0001, w_h};
                else                n_code = {8'd0, 1'b0, w_luma[7:5], w_h};
            end else begin
                n_code = {12'd0, w_luma[7:4]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) r_code <= n_code;
    end

endmodule

FILE: rtl/core/rgb_to_palette_code_unit.sv
// ============================================================================
// rgb_to_palette_code_unit - RGB pixel to palette code converter
// Six-stage pipeline: luma, chroma, fold/saturation, two divider stages,
// encode/output register.
// ============================================================================
//  Channel   Dir  Signals                          Content
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: red, green, blue
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: pixel_code
//  cfg       in   i_cfg_we, i_cfg_wdata            mode register
//
//  One item per cycle sustained while the output keeps tready high.
//  Each stage holds its own valid bit; a stall at the output fills bubbles
//  upstream before input ready drops, with ready chained back stage by stage.
//  Synchronous active-low reset clears all valid bits and sets mode to 3.
//  Mode is read at the encode stage; write it only while the unit is empty.
// ============================================================================
module rgb_to_palette_code_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] pixel_code
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);

    logic           r_mode;
    logic [1:0]     r_mode_q;
    logic           w_v2, w_r2;
    logic           w_v3, w_r3;
    logic           w_v4, w_r4;
    rptc_pkg::t_s2  w_s2;
    rptc_pkg::t_div w_s3;
    rptc_pkg::t_div w_s4;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_q <= rptc_pkg::MODE_RESET;
            r_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode_q <= i_cfg_wdata;
            r_mode   <= 1'b1;
        end
    end

    rptc_luma_chroma u_luma_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_pix   (rptc_pkg::t_pix'(i_s_axis_tdata)),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_data  (w_s2)
    );

    rptc_fold_sat u_fold_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_r2),
        .i_data  (w_s2),
        .o_valid (w_v3),
        .i_ready (w_r3),
        .o_data  (w_s3)
    );

    rptc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_ready (w_r3),
        .i_data  (w_s3),
        .o_valid (w_v4),
        .i_ready (w_r4),
        .o_data  (w_s4)
    );

    rptc_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode_q),
        .i_valid (w_v4),
        .o_ready (w_r4),
        .i_data  (w_s4),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_code  (o_m_axis_tdata)
    );

    // Reset loads the default mode
    a_mode_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_mode_q == rptc_pkg::MODE_RESET && !r_mode))
        else $error("mode not at reset value after reset");

    // A write lands in the mode register
    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_mode && r_mode_q == $past(i_cfg_wdata)))
        else $error("mode write lost");

    // An empty output stage never blocks the input
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // Without a held output item the pipeline can always advance
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> (w_r2 && w_r3 && w_r4 && o_s_axis_tready))
        else $error("pipeline stalled with output ready");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench for the RGB to palette code unit
// Drives pixel items on the input stream and checks every palette code on
// the output stream against a predictor kept in the bench. The run covers
// the reset mode and every written mode. Both sides idle at random, and one
// phase holds the output off long enough to stall the input.
// ============================================================================
module tb_top;

    // Modes without a name in the package; both select the 16-bit encoding
    localparam logic [1:0] MODE_16BIT_1 = 2'd1;
    localparam logic [1:0] MODE_16BIT_2 = 2'd2;

    localparam int PHASE_ITEMS = 112;
    localparam int HOLD_CYCLES = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 12;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata  = '0;   // [7:0] red, [15:8] green, [23:16] blue
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;         // [15:0] pixel_code
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_wdata     = '0;

    // Bench bookkeeping
    logic [23:0] pixel_q[$];     // pixels waiting to be driven
    logic [15:0] code_q[$];      // predicted codes, oldest first
    logic [1:0]  mode_shadow = rptc_pkg::MODE_RESET;
    logic        s_fire = 1'b0;
    logic        m_fire = 1'b0;
    int          in_total = 0;
    int          out_count = 0;
    int          err_cnt = 0;
    int          stall_cnt = 0;
    int          send_max = 4;
    int          recv_max = 4;
    int          hold_req_cnt = 0;

    rgb_to_palette_code_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Luma and the raw chroma pair of one pixel
    function automatic void split_pixel(input rptc_pkg::t_pix px, output int luma,
                                        output int u, output int v);
        int r, g, b;
        r = px.red;
        g = px.green;
        b = px.blue;
        luma = (77 * r + 29 * b + 150 * g) >> 8;
        u = 126 * (b - luma);
        v = 224 * (r - luma);
    endfunction

    // Palette code the unit should produce for one pixel in a given mode
    function automatic logic [15:0] predict_code(input rptc_pkg::t_pix px,
                                                 input logic [1:0] m);
        int luma, u, v, fy, fx, tmp, ang, q, big, sml, sat, h;
        logic ny, nx, sw;
        logic [5:0] hue;
        logic [15:0] code;
        split_pixel(px, luma, u, v);

        // Hue: fold the floored chroma into the first octant, then unfold
        fy = v >>> 8;
        fx = u >>> 8;
        ny = (fy < 0);
        nx = (fx < 0);
        if (ny) fy = -fy;
        if (nx) fx = -fx;
        sw = (fy > fx);
        if (sw) begin
            tmp = fx;
            fx = fy;
            fy = tmp;
        end
        if (fx == 0) begin
            ang = 0;                 // zero chroma vector
        end else begin
            ang = (fx == fy) ? 32 : (fy * 32) / fx;
            if (sw) ang = 64 - ang;
            if (nx) ang = 128 - ang;
            if (ny) ang = -ang;
        end
        q = ang >>> 2;
        tmp = q + 79;
        hue = tmp[5:0];

        // Saturation: max + 3/8 min, rounded, clamped
        big = (u < 0) ? -u : u;
        sml = (v < 0) ? -v : v;
        if (sml > big) begin
            tmp = big;
            big = sml;
            sml = tmp;
        end
        sat = (big + sml * 3 / 8 + 1024) >> 11;
        if (sat > 15) sat = 15;

        if (m != rptc_pkg::MODE_8BIT) begin
            if (sat == 0) begin
                code = 16'(luma >> 1);
            end else if (sat < 4) begin
                code = 16'((sat << 12) | ((hue & 6'h3e) << 6) | (luma >> 1));
            end else begin
                code = 16'((sat << 12) | (hue << 6) | (luma >> 2));
            end
        end else begin
            h = hue >> 2;
            if (sat > 8)
                code = 16'(192 + (luma / 64) * 16 + h);
            else if (sat > 4)
                code = 16'(128 + (luma / 64) * 16 + h);
            else if (sat > 0)
                code = (luma < 32) ? 16'(16 + h) : 16'((luma / 32) * 16 + h);
            else
                code = 16'(luma / 16);
        end
        return code;
    endfunction

    // Input side: one pixel per item, random gap before each
    always @(negedge i_clk) begin : drive_pixels
        logic        nxt_valid;
        logic [23:0] nxt_data;
        int          send_gap;
        nxt_valid = i_s_axis_tvalid;
        nxt_data  = i_s_axis_tdata;
        if (i_s_axis_tvalid && s_fire) begin
            nxt_valid = 1'b0;
            send_gap  = $urandom_range(0, send_max);
        end
        if (!nxt_valid && pixel_q.size() != 0) begin
            if (send_gap == 0) begin
                nxt_data  = pixel_q.pop_front();
                nxt_valid = 1'b1;
            end else begin
                send_gap--;
            end
        end
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= nxt_data;
    end

    // Output side: random stall after each item, plus a long hold on request
    always @(negedge i_clk) begin : drive_ready
        int ready_gap;
        int hold_left;
        int hold_seen;
        if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (m_fire) ready_gap = $urandom_range(0, recv_max);
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Predict on input accept, compare on output accept
    always @(posedge i_clk) begin : check_codes
        logic [15:0] want;
        s_fire <= i_s_axis_tvalid && o_s_axis_tready;
        m_fire <= o_m_axis_tvalid && i_m_axis_tready;
        if (i_s_axis_tvalid && o_s_axis_tready)
            code_q.push_back(predict_code(i_s_axis_tdata, mode_shadow));
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            out_count++;
            if (code_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected code, expected none, actual %h",
                         $realtime, o_m_axis_tdata);
            end else begin
                want = code_q.pop_front();
                if (want !== o_m_axis_tdata) begin
                    err_cnt++;
                    $display("%0t: pixel_code mismatch, expected %h, actual %h",
                             $realtime, want, o_m_axis_tdata);
                end
            end
        end
    end

    // Watchdog: cycles without any accepted item
    always @(posedge i_clk) begin : watchdog
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Wait until every pixel sent so far has come back as a code
    task automatic drain();
        while (out_count < in_total) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        mode_shadow = m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : run_test
        logic [23:0]     dir_list[$];
        logic [23:0]     pw;
        logic [1:0]      phase_mode[6];
        rptc_pkg::t_pix  p;
        int              luma, u, v, fy, fx;
        int              n, c, ph, kind, base, ch, found;

        phase_mode = '{MODE_16BIT_1, rptc_pkg::MODE_8BIT, MODE_16BIT_2,
                       rptc_pkg::MODE_RESET, rptc_pkg::MODE_8BIT, MODE_16BIT_1};

        // Directed pixels, hex bbggrr
        dir_list = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00, 24'hff0000,
                     24'h00ffff, 24'hffff00, 24'hff00ff, 24'h808080, 24'h0a0a0a,
                     24'h80808c, 24'hfffeff};
        // Diagonal: floored chroma components of equal size
        found = 0;
        for (n = 0; n < 200000 && found < 2; n++) begin
            p.red   = $urandom_range(0, 255);
            p.green = $urandom_range(0, 255);
            p.blue  = $urandom_range(0, 255);
            split_pixel(p, luma, u, v);
            fy = v >>> 8;
            fx = u >>> 8;
            if (fx != 0 && (fx == fy || fx == -fy)) begin
                dir_list.push_back(p);
                found++;
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed set in the reset mode, then in 8-bit mode
        foreach (dir_list[i]) pixel_q.push_back(dir_list[i]);
        in_total += dir_list.size();
        drain();
        write_mode(rptc_pkg::MODE_8BIT);
        foreach (dir_list[i]) pixel_q.push_back(dir_list[i]);
        in_total += dir_list.size();
        drain();

        // Random phases, one mode each
        for (ph = 0; ph < 6; ph++) begin
            write_mode(phase_mode[ph]);
            send_max = (ph % 2) ? 0 : 4;
            recv_max = (ph % 2) ? 0 : 4;
            if (ph == 2) begin
                // sender keeps offering while the output is held off
                send_max = 0;
                hold_req_cnt++;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(0, 3);
                base = $urandom_range(0, 255);
                for (c = 0; c < 3; c++) begin
                    case (kind)
                        0, 1: ch = $urandom_range(0, 255);
                        2: ch = base + int'($urandom_range(0, 16)) - 8;   // near grey
                        default: ch = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
                    endcase
                    if (ch < 0) ch = 0;
                    else if (ch > 255) ch = 255;
                    pw[8*c +: 8] = ch[7:0];
                end
                pixel_q.push_back(pw);
                in_total++;
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && code_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rptc_pkg.sv
rtl/core/rptc_luma_chroma.sv
rtl/core/rptc_fold_sat.sv
rtl/core/rptc_divider.sv
rtl/core/rptc_encode.sv
rtl/core/rgb_to_palette_code_unit.sv
bench/tb_top.sv
